/* hw/rtl/lbc_pkg.sv */
// ----------------------------------------------------------------------------
// lbc_pkg
// Shared constants and types for the LBA to CHS converter.
// ----------------------------------------------------------------------------
package lbc_pkg;

   localparam int ADDR_W      = 32;
   localparam int SPT_W       = 6;
   localparam int HEADS_W     = 9;
   localparam int CYL_W       = 16;
   localparam int HEAD_W      = 8;
   localparam int CSR_DATA_W  = 9;
   localparam int CSR_INDEX_W = 2;

   localparam logic [SPT_W-1:0]   SPT_RESET   = 6'd63;
   localparam logic [HEADS_W-1:0] HEADS_RESET = 9'd16;
   localparam logic [HEADS_W-1:0] HEADS_MAX   = 9'd256;

   // one cell per quotient bit in each divider chain, plus the output register
   localparam int LATENCY = 2 * ADDR_W + 1;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_SPT   = 2'd0,
      CSR_HEADS = 2'd1
   } csr_index_type;

endpackage

/* hw/rtl/lbc_div_cell.sv */
// ----------------------------------------------------------------------------
// lbc_div_cell
// One restoring division step: develops one quotient bit and hands the
// partial remainder, dividend/quotient word, divisor and side data onward.
// ----------------------------------------------------------------------------
module lbc_div_cell #(
   parameter int NW = lbc_pkg::ADDR_W,
   parameter int DW = lbc_pkg::SPT_W,
   parameter int XW = lbc_pkg::HEADS_W
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   input  logic [DW-1:0] in_rem,
   input  logic [NW-1:0] in_acc,
   input  logic [DW-1:0] in_div,
   input  logic [XW-1:0] in_extra,
   output logic          out_valid,
   output logic [DW-1:0] out_rem,
   output logic [NW-1:0] out_acc,
   output logic [DW-1:0] out_div,
   output logic [XW-1:0] out_extra
);

   logic          valid_ff;
   logic [DW-1:0] rem_ff,   rem_in;
   logic [NW-1:0] acc_ff,   acc_in;
   logic [DW-1:0] div_ff;
   logic [XW-1:0] extra_ff;
   logic [DW:0]   trial;
   logic [DW:0]   diff;
   logic          ge;

   // remainder stays below the divisor, so trial < 2*divisor and diff fits
   always_comb begin
      trial  = {in_rem, in_acc[NW-1]};
      diff   = trial - {1'b0, in_div};
      ge     = (trial >= {1'b0, in_div});
      rem_in = ge ? diff[DW-1:0] : trial[DW-1:0];
      acc_in = {in_acc[NW-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff   <= rem_in;
      acc_ff   <= acc_in;
      div_ff   <= in_div;
      extra_ff <= in_extra;
   end

   assign out_valid = valid_ff;
   assign out_rem   = rem_ff;
   assign out_acc   = acc_ff;
   assign out_div   = div_ff;
   assign out_extra = extra_ff;

endmodule

/* hw/rtl/lbc_div_chain.sv */
// ----------------------------------------------------------------------------
// lbc_div_chain
// Row of NW division cells: a fully pipelined NW-bit by DW-bit divider
// taking one dividend per cycle.
// ----------------------------------------------------------------------------
module lbc_div_chain #(
   parameter int NW = lbc_pkg::ADDR_W,
   parameter int DW = lbc_pkg::SPT_W,
   parameter int XW = lbc_pkg::HEADS_W
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   input  logic [NW-1:0] in_dividend,
   input  logic [DW-1:0] in_divisor,
   input  logic [XW-1:0] in_extra,
   output logic          out_valid,
   output logic [NW-1:0] out_quotient,
   output logic [DW-1:0] out_remainder,
   output logic [XW-1:0] out_extra
);

   logic          valid_w [NW+1];
   logic [DW-1:0] rem_w   [NW+1];
   logic [NW-1:0] acc_w   [NW+1];
   logic [DW-1:0] div_w   [NW+1];
   logic [XW-1:0] extra_w [NW+1];

   assign valid_w[0] = in_valid;
   assign rem_w[0]   = '0;
   assign acc_w[0]   = in_dividend;
   assign div_w[0]   = in_divisor;
   assign extra_w[0] = in_extra;

   for (genvar i = 0; i < NW; i++) begin : g_cell
      lbc_div_cell #(
         .NW(NW),
         .DW(DW),
         .XW(XW)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .in_valid (valid_w[i]),
         .in_rem   (rem_w[i]),
         .in_acc   (acc_w[i]),
         .in_div   (div_w[i]),
         .in_extra (extra_w[i]),
         .out_valid(valid_w[i+1]),
         .out_rem  (rem_w[i+1]),
         .out_acc  (acc_w[i+1]),
         .out_div  (div_w[i+1]),
         .out_extra(extra_w[i+1])
      );
   end

   assign out_valid     = valid_w[NW];
   assign out_quotient  = acc_w[NW];
   assign out_remainder = rem_w[NW];
   assign out_extra     = extra_w[NW];

endmodule

/* hw/rtl/lba_to_chs_converter.sv */
// ----------------------------------------------------------------------------
// lba_to_chs_converter
// Converts a logical block address to cylinder/head/sector form.
// ----------------------------------------------------------------------------
// Pipeline: an accepted start passes 32 cells dividing by sectors per track,
//   32 cells dividing by head count and the output register to rsp_valid.
// Throughput: one address per cycle; busy is always low.
// The receiver cannot stall: rsp_valid marks each result for one cycle.
// Reset (synchronous): empties the pipeline, sectors per track = 63,
//   head count = 16.
// ----------------------------------------------------------------------------
module lba_to_chs_converter (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic [lbc_pkg::ADDR_W-1:0]       req_block_address,
   output logic                             rsp_valid,
   output logic [lbc_pkg::CYL_W-1:0]        rsp_cylinder,
   output logic [lbc_pkg::HEAD_W-1:0]       rsp_head,
   output logic [lbc_pkg::SPT_W-1:0]        rsp_sector,
   output logic                             rsp_cylinder_overflow,
   input  logic                             csr_we,
   input  logic [lbc_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [lbc_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   localparam int NW = lbc_pkg::ADDR_W;
   localparam int SW = lbc_pkg::SPT_W;
   localparam int HW = lbc_pkg::HEADS_W;

   logic [SW-1:0] spt_ff,   spt_in;
   logic [HW-1:0] heads_ff, heads_in;
   logic [SW-1:0] spt_eff;
   logic [HW-1:0] heads_eff;
   logic          accept;

   logic          trk_valid;
   logic [NW-1:0] trk_quot;
   logic [SW-1:0] trk_rem;
   logic [HW-1:0] trk_heads;

   logic          cyl_valid;
   logic [NW-1:0] cyl_quot;
   logic [HW-1:0] cyl_rem;
   logic [SW-1:0] cyl_sector_rem;

   logic                        rsp_valid_ff;
   logic [lbc_pkg::CYL_W-1:0]   cyl_ff;
   logic [lbc_pkg::HEAD_W-1:0]  head_ff;
   logic [SW-1:0]               sector_ff, sector_in;
   logic                        ovf_ff;

   // ---------------- configuration registers ----------------
   always_comb begin
      spt_in   = spt_ff;
      heads_in = heads_ff;
      if (csr_we) begin
         case (csr_index)
            lbc_pkg::CSR_SPT:   spt_in   = csr_wdata[SW-1:0];
            lbc_pkg::CSR_HEADS: heads_in = csr_wdata[HW-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         spt_ff   <= lbc_pkg::SPT_RESET;
         heads_ff <= lbc_pkg::HEADS_RESET;
      end else begin
         spt_ff   <= spt_in;
         heads_ff <= heads_in;
      end
   end

   // zero acts as one; head count saturates so the head fits 8 bits
   always_comb begin
      spt_eff = (spt_ff == '0) ? SW'(1) : spt_ff;
      if (heads_ff == '0) begin
         heads_eff = HW'(1);
      end else if (heads_ff > lbc_pkg::HEADS_MAX) begin
         heads_eff = lbc_pkg::HEADS_MAX;
      end else begin
         heads_eff = heads_ff;
      end
   end

   assign busy   = 1'b0;
   assign accept = start && !busy;

   // ---------------- address / sectors per track ----------------
   lbc_div_chain #(
      .NW(NW),
      .DW(SW),
      .XW(HW)
   ) u_trk_div (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (accept),
      .in_dividend  (req_block_address),
      .in_divisor   (spt_eff),
      .in_extra     (heads_eff),
      .out_valid    (trk_valid),
      .out_quotient (trk_quot),
      .out_remainder(trk_rem),
      .out_extra    (trk_heads)
   );

   // ---------------- track / head count ----------------
   lbc_div_chain #(
      .NW(NW),
      .DW(HW),
      .XW(SW)
   ) u_cyl_div (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (trk_valid),
      .in_dividend  (trk_quot),
      .in_divisor   (trk_heads),
      .in_extra     (trk_rem),
      .out_valid    (cyl_valid),
      .out_quotient (cyl_quot),
      .out_remainder(cyl_rem),
      .out_extra    (cyl_sector_rem)
   );

   // ---------------- result register ----------------
   assign sector_in = cyl_sector_rem + SW'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cyl_valid;
      end
   end

   always_ff @(posedge clock) begin
      cyl_ff    <= cyl_quot[lbc_pkg::CYL_W-1:0];
      head_ff   <= cyl_rem[lbc_pkg::HEAD_W-1:0];
      sector_ff <= sector_in;
      ovf_ff    <= |cyl_quot[NW-1:lbc_pkg::CYL_W];
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_cylinder          = cyl_ff;
   assign rsp_head              = head_ff;
   assign rsp_sector            = sector_ff;
   assign rsp_cylinder_overflow = ovf_ff;

`ifndef ASSERT_OFF
   // sector is counted from one and never passes the track length
   a_sector_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_sector != '0) && (rsp_sector <= spt_eff))
      else $error("sector out of range");

   // head stays below the effective head count
   a_head_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ({1'b0, rsp_head} < heads_eff))
      else $error("head out of range");

   // the second divider only ever sees items handed over by the first
   a_chain_order: assert property (@(posedge clock) disable iff (reset)
      cyl_valid |-> $past(trk_valid, NW))
      else $error("cylinder stage valid without a track stage item");
`endif

endmodule
